[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MSM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/msm_pkg.sv]
// ---------------------------------------------------------------------------
// Slot manager package
// Command and status codes, controller states and control structs.
// ---------------------------------------------------------------------------
package msm_pkg;

  localparam int DEF_NUM_SLOTS   = 4;
  localparam int DEF_NUM_WRITERS = 2;
  localparam int DEF_N_READERS   = 2;

  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 3;
  localparam int WID_W       = 4;
  localparam int SLOT_OUT_W  = 2;

  typedef enum logic [1:0] {
    CMD_WR_ACQ = 2'd0,
    CMD_WR_REL = 2'd1,
    CMD_RD_ACQ = 2'd2,
    CMD_RD_REL = 2'd3
  } msm_cmd_t;

  typedef enum logic [2:0] {
    ST_GRANTED    = 3'd0,
    ST_NO_SLOT    = 3'd1,
    ST_BAD_WRITER = 3'd2,
    ST_RELEASED   = 3'd3,
    ST_NOT_HELD   = 3'd4
  } msm_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_EMIT
  } msm_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic emit;
  } msm_ctl_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic out_free;
  } msm_sts_t;

endpackage

[rtl/core/msm_ctrl.sv]
// ---------------------------------------------------------------------------
// Slot manager controller
// Sequences load, execute, slot scan and result hand-off for one word.
// ---------------------------------------------------------------------------
module msm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  msm_pkg::msm_sts_t sts,
  output msm_pkg::msm_ctl_t ctl
);
  import msm_pkg::*;

  msm_state_t state_r;
  msm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = sts.need_scan ? S_SCAN : S_EMIT;
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        ctl.load  = in_tvalid;
      end
      S_EXEC: ctl.exec = 1'b1;
      S_SCAN: ctl.scan = 1'b1;
      S_EMIT: ctl.emit = sts.out_free;
      default: ctl = '0;
    endcase
  end

endmodule

[rtl/core/msm_dp.sv]
// ---------------------------------------------------------------------------
// Slot manager datapath
// Slot tables, writer and reader holds, free-slot scan and result registers.
// ---------------------------------------------------------------------------
module msm_dp #(
  parameter int NUM_SLOTS   = msm_pkg::DEF_NUM_SLOTS,
  parameter int NUM_WRITERS = msm_pkg::DEF_NUM_WRITERS,
  parameter int N_READERS   = msm_pkg::DEF_N_READERS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [msm_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic [msm_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  msm_pkg::msm_ctl_t                ctl,
  output msm_pkg::msm_sts_t                sts,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [msm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [msm_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import msm_pkg::*;

  localparam int SL_W  = $clog2(NUM_SLOTS);
  localparam int WR_W  = (NUM_WRITERS > 1) ? $clog2(NUM_WRITERS) : 1;
  localparam int RD_W  = (N_READERS > 1) ? $clog2(N_READERS) : 1;
  localparam int CNT_W = $clog2(N_READERS + 1);

  msm_cmd_t             cmd_r;
  logic [WID_W-1:0]     wid_r;
  logic                 rid_r;
  logic                 pub_r;

  logic [SL_W-1:0]        latest_r;
  logic                   wh_v_r [NUM_WRITERS];
  logic [SL_W-1:0]        wh_s_r [NUM_WRITERS];
  logic                   rh_v_r [N_READERS];
  logic [SL_W-1:0]        rh_s_r [N_READERS];
  logic [CNT_W-1:0]       cnt_r  [NUM_SLOTS];
  logic                   bw_r   [NUM_SLOTS];
  logic [N_READERS-1:0]   ard_r  [NUM_SLOTS];
  logic [SL_W-1:0]        scan_r;

  msm_status_t          res_st_r;
  logic [SL_W-1:0]      res_slot_r;
  logic                 out_valid_r;
  msm_status_t          out_st_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;

  logic            w_ok;
  logic [WR_W-1:0] widx;
  logic [RD_W-1:0] ridx;
  logic            wh_hit;
  logic            rh_hit;
  logic            rd_take;
  logic            scan_free;
  logic            scan_last;
  msm_status_t     ex_st;
  logic [SL_W-1:0] ex_slot;
  logic [SL_W-1:0] wh_slot;
  logic [SL_W-1:0] rh_slot;

  assign w_ok      = int'(wid_r) < NUM_WRITERS;
  assign widx      = wid_r[WR_W-1:0];
  assign ridx      = (int'(rid_r) < N_READERS) ? RD_W'(rid_r) : '0;
  assign wh_hit    = w_ok && wh_v_r[widx];
  assign rh_hit    = rh_v_r[ridx];
  assign wh_slot   = wh_s_r[widx];
  assign rh_slot   = rh_s_r[ridx];
  assign rd_take   = !rh_hit && !ard_r[latest_r][ridx];
  assign scan_free = (cnt_r[scan_r] == '0) && (scan_r != latest_r) && !bw_r[scan_r];
  assign scan_last = scan_r == SL_W'(NUM_SLOTS - 1);

  assign sts.need_scan = (cmd_r == CMD_WR_ACQ) && w_ok && !wh_v_r[widx];
  assign sts.scan_done = scan_free || scan_last;
  assign sts.out_free  = !out_valid_r || out_tready;

  always_comb begin
    ex_st   = ST_NO_SLOT;
    ex_slot = '0;
    case (cmd_r)
      CMD_WR_ACQ: begin
        if (!w_ok) begin
          ex_st = ST_BAD_WRITER;
        end else if (wh_hit) begin
          ex_st   = ST_GRANTED;
          ex_slot = wh_slot;
        end
      end
      CMD_WR_REL: begin
        if (!w_ok) ex_st = ST_BAD_WRITER;
        else if (!wh_hit) ex_st = ST_NOT_HELD;
        else ex_st = ST_RELEASED;
      end
      CMD_RD_ACQ: begin
        if (rh_hit) begin
          ex_st   = ST_GRANTED;
          ex_slot = rh_slot;
        end else if (rd_take) begin
          ex_st   = ST_GRANTED;
          ex_slot = latest_r;
        end
      end
      CMD_RD_REL: begin
        ex_st = rh_hit ? ST_RELEASED : ST_NOT_HELD;
      end
      default: ex_st = ST_NO_SLOT;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latest_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_WRITERS; i++) wh_v_r[i] <= 1'b0;
      for (int i = 0; i < N_READERS; i++) rh_v_r[i] <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        cnt_r[i] <= '0;
        bw_r[i]  <= 1'b0;
        ard_r[i] <= '1;
      end
    end else begin
      if (ctl.exec) begin
        case (cmd_r)
          CMD_WR_REL: begin
            if (wh_hit) begin
              if (pub_r) begin
                ard_r[wh_slot] <= '0;
                latest_r       <= wh_slot;
              end
              bw_r[wh_slot] <= 1'b0;
              wh_v_r[widx]  <= 1'b0;
            end
          end
          CMD_RD_ACQ: begin
            if (rd_take) begin
              ard_r[latest_r][ridx] <= 1'b1;
              cnt_r[latest_r]       <= cnt_r[latest_r] + CNT_W'(1);
              rh_v_r[ridx]          <= 1'b1;
            end
          end
          CMD_RD_REL: begin
            if (rh_hit) begin
              if (cnt_r[rh_slot] != '0) cnt_r[rh_slot] <= cnt_r[rh_slot] - CNT_W'(1);
              rh_v_r[ridx] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (ctl.scan && scan_free) begin
        bw_r[scan_r]  <= 1'b1;
        ard_r[scan_r] <= '1;
        wh_v_r[widx]  <= 1'b1;
      end
      if (ctl.emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= msm_cmd_t'(in_tuser);
      wid_r <= in_tdata[WID_W-1:0];
      rid_r <= in_tdata[WID_W];
      pub_r <= in_tdata[WID_W+1];
    end
    if (ctl.exec) begin
      res_st_r   <= ex_st;
      res_slot_r <= ex_slot;
      scan_r     <= '0;
      if (cmd_r == CMD_RD_ACQ && rd_take) rh_s_r[ridx] <= latest_r;
    end
    if (ctl.scan) begin
      if (scan_free) begin
        res_st_r     <= ST_GRANTED;
        res_slot_r   <= scan_r;
        wh_s_r[widx] <= scan_r;
      end else if (scan_last) begin
        res_st_r   <= ST_NO_SLOT;
        res_slot_r <= '0;
      end else begin
        scan_r <= scan_r + SL_W'(1);
      end
    end
    if (ctl.emit) begin
      out_st_r   <= res_st_r;
      out_slot_r <= res_slot_r[SLOT_OUT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = OUT_TDATA_W'(out_slot_r);

endmodule

[rtl/core/multi_buffer_slot_manager_unit.sv]
// ---------------------------------------------------------------------------
// Multi-buffer slot manager: each accepted word is executed, then a free-slot
// scan runs on a writer acquire with no held slot, then the result is handed off.
// One word at a time; a new word is taken only once the last result is registered.
// Synchronous reset clears holds, counts and write marks, sets read marks.
// ---------------------------------------------------------------------------
module multi_buffer_slot_manager_unit #(
  parameter int NUM_SLOTS   = msm_pkg::DEF_NUM_SLOTS,
  parameter int NUM_WRITERS = msm_pkg::DEF_NUM_WRITERS,
  parameter int N_READERS   = msm_pkg::DEF_N_READERS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [msm_pkg::IN_TDATA_W-1:0]  in_tdata,   // writer_id[3:0], reader_id, publish
  input  logic [msm_pkg::IN_TUSER_W-1:0]  in_tuser,   // cmd
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [msm_pkg::OUT_TDATA_W-1:0] out_tdata,  // slot[1:0]
  output logic [msm_pkg::OUT_TUSER_W-1:0] out_tuser   // status
);
  import msm_pkg::*;

  msm_ctl_t ctl;
  msm_sts_t sts;

  msm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  msm_dp #(
    .NUM_SLOTS   (NUM_SLOTS),
    .NUM_WRITERS (NUM_WRITERS),
    .N_READERS   (N_READERS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .ctl        (ctl),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[rtl/core/msm_chk.sv]
// ---------------------------------------------------------------------------
// Slot manager port checker
// Port-level properties of the slot manager, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module msm_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [msm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [msm_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import msm_pkg::*;

  `MSM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `MSM_ASSERT_SAME(a_status_code, out_tvalid, out_tuser <= ST_NOT_HELD)
  `MSM_ASSERT_SAME(a_slot_zero, out_tvalid && out_tuser != ST_GRANTED, out_tdata == '0)
  `MSM_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

endmodule

bind multi_buffer_slot_manager_unit msm_chk u_msm_chk (.*);
